/* rtl/core/text_console_writer_assert.svh */
// Assertion macros shared by the text console writer modules.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Condition must never hold at a clock edge outside reset.
`define TCW_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

// Antecedent must imply the consequent in the same cycle.
`define TCW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/tcw_pkg.sv */
// Shared constants, command codes and control/status types of the text console writer.
package tcw_pkg;

   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = COLS * ROWS;
   localparam int MEM_AW = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;

   localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0700;
   localparam logic [7:0]        RESET_BLANK_ATTR = 8'h07;

   localparam logic [1:0] CMD_PUT     = 2'd0;
   localparam logic [1:0] CMD_NEWLINE = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   typedef struct packed {
      logic capture;
      logic exec;
      logic cnt_zero;
      logic cnt_inc;
      logic init_wr;
      logic clr_wr;
      logic copy_rd;
      logic blank_stage;
      logic load_rsp;
   } tcw_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       need_scroll;
      logic       cnt_last_copy;
      logic       cnt_last;
      logic       out_free;
   } tcw_status_type;

endpackage

/* rtl/core/text_console_writer.sv */
// Text console writer: a screen of COLS x ROWS attribute/character cells with a cursor,
// taking put, newline, clear and read commands and returning one result per command.
// After reset a clearing pass writes every cell of the screen memory, one per cycle,
// before the first command transfer; configuration writes are taken at any time. Put
// without scroll, newline without scroll and read execute on the screen memory (one read
// and one write port) and then load the result register, during which the next command
// may already transfer. Clear and scroll sweep the screen memory, which moves one cell
// per cycle. The result register holds a result until its transfer while the next
// command executes.
module text_console_writer import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_char_code,
   input  logic [7:0]        req_attribute,
   input  logic [ADDR_W-1:0] req_cell_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_cursor_position,
   output logic [CELL_W-1:0] rsp_cell_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_blank_attribute
);

   tcw_cmd_type    ctl;
   tcw_status_type stat;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   tcw_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .stat                (stat),
      .req_cmd             (req_cmd),
      .req_char_code       (req_char_code),
      .req_attribute       (req_attribute),
      .req_cell_address    (req_cell_address),
      .csr_valid           (csr_valid),
      .csr_blank_attribute (csr_blank_attribute),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_data       (rsp_cell_data)
   );

endmodule

/* rtl/core/tcw_ctrl.sv */
// Controller state machine of the text console writer.
module tcw_ctrl import tcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  tcw_status_type stat,
   output tcw_cmd_type    ctl
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_CLEAR  = 3'd3;
   localparam logic [2:0] ST_SCOPY  = 3'd4;
   localparam logic [2:0] ST_SBLANK = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            ctl.init_wr = 1'b1;
            ctl.cnt_inc = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            priority if (stat.cmd == CMD_CLEAR) begin
               ctl.cnt_zero = 1'b1;
               state_in     = ST_CLEAR;
            end else if (stat.need_scroll) begin
               ctl.cnt_zero = 1'b1;
               state_in     = ST_SCOPY;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CLEAR: begin
            ctl.clr_wr  = 1'b1;
            ctl.cnt_inc = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_SCOPY: begin
            ctl.copy_rd = 1'b1;
            ctl.cnt_inc = 1'b1;
            if (stat.cnt_last_copy) begin
               state_in = ST_SBLANK;
            end
         end
         ST_SBLANK: begin
            ctl.blank_stage = 1'b1;
            ctl.cnt_inc     = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               ctl.load_rsp = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  ctl.capture = 1'b1;
                  state_in    = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   `include "text_console_writer_assert.svh"

   `TCW_ASSERT_IMPLY(a_load_needs_room, clock, reset, ctl.load_rsp, stat.out_free)
   `TCW_ASSERT_IMPLY(a_accept_only_when_free, clock, reset, ctl.capture,
      (state_ff == ST_IDLE) || (state_ff == ST_FINISH && ctl.load_rsp))
   `TCW_ASSERT_NEVER(a_scroll_leaves_no_exec, clock, reset,
      $past(state_ff == ST_SBLANK) && state_ff == ST_EXEC)

endmodule

/* rtl/core/tcw_dp.sv */
// Datapath of the text console writer: screen memory, cursor, sweep counter and result register.
module tcw_dp import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  tcw_cmd_type       ctl,
   output tcw_status_type    stat,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_char_code,
   input  logic [7:0]        req_attribute,
   input  logic [ADDR_W-1:0] req_cell_address,
   input  logic              csr_valid,
   input  logic [7:0]        csr_blank_attribute,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_cursor_position,
   output logic [CELL_W-1:0] rsp_cell_data
);

   logic [CELL_W-1:0] mem [CELLS];

   logic [1:0]        cmd_ff;
   logic [7:0]        char_ff;
   logic [7:0]        attr_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]        blank_attr_ff;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [MEM_AW-1:0] cnt_ff;
   logic              wr_pend_ff;
   logic [MEM_AW-1:0] wr_addr_ff;
   logic              wr_blank_ff;
   logic [CELL_W-1:0] rdata_ff;
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_pos_ff;
   logic [CELL_W-1:0] rsp_data_ff;

   logic [CELL_W-1:0] blank_cell;
   logic [MEM_AW-1:0] cur_pos;
   logic              addr_ok;
   logic [MEM_AW-1:0] read_idx;
   logic [MEM_AW-1:0] raddr;
   logic              re;
   logic              we;
   logic              direct_we;
   logic [MEM_AW-1:0] waddr;
   logic [CELL_W-1:0] wdata;
   logic              col_last;
   logic              row_last;
   logic              out_free;

   function automatic logic req_addr_in_range(input logic [ADDR_W-1:0] a);
      return a < ADDR_W'(CELLS);
   endfunction

   assign blank_cell = {blank_attr_ff, 8'h00};
   assign cur_pos    = MEM_AW'(row_ff) * MEM_AW'(COLS) + MEM_AW'(col_ff);
   assign addr_ok    = req_addr_in_range(addr_ff);
   assign read_idx   = addr_ok ? MEM_AW'(addr_ff) : '0;
   assign col_last   = (col_ff == COL_W'(COLS - 1));
   assign row_last   = (row_ff == ROW_W'(ROWS - 1));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.cmd           = cmd_ff;
      stat.need_scroll   = row_last &&
                           ((cmd_ff == CMD_PUT && col_last) || cmd_ff == CMD_NEWLINE);
      stat.cnt_last_copy = (cnt_ff == MEM_AW'(CELLS - COLS - 1));
      stat.cnt_last      = (cnt_ff == MEM_AW'(CELLS - 1));
      stat.out_free      = out_free;
   end

   // cursor advance, saturating at the bottom row
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctl.exec && (cmd_ff == CMD_PUT || cmd_ff == CMD_NEWLINE)) begin
         if (cmd_ff == CMD_PUT && !col_last) begin
            col_in = col_ff + COL_W'(1);
         end else begin
            col_in = '0;
            if (!row_last) begin
               row_in = row_ff + ROW_W'(1);
            end
         end
      end
   end

   assign direct_we = ctl.init_wr || ctl.clr_wr || (ctl.exec && cmd_ff == CMD_PUT);

   always_comb begin
      we    = 1'b0;
      waddr = cnt_ff;
      wdata = blank_cell;
      priority if (wr_pend_ff) begin
         we    = 1'b1;
         waddr = wr_addr_ff;
         wdata = wr_blank_ff ? blank_cell : rdata_ff;
      end else if (ctl.init_wr) begin
         we    = 1'b1;
         wdata = RESET_BLANK;
      end else if (ctl.clr_wr) begin
         we    = 1'b1;
      end else if (ctl.exec && cmd_ff == CMD_PUT) begin
         we    = 1'b1;
         waddr = cur_pos;
         wdata = {attr_ff, char_ff};
      end
   end

   assign re    = ctl.copy_rd || (ctl.exec && cmd_ff == CMD_READ);
   assign raddr = ctl.copy_rd ? cnt_ff + MEM_AW'(COLS) : read_idx;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_cmd;
         char_ff <= req_char_code;
         attr_ff <= req_attribute;
         addr_ff <= req_cell_address;
      end
      wr_addr_ff  <= cnt_ff;
      wr_blank_ff <= ctl.blank_stage;
      if (ctl.load_rsp) begin
         rsp_pos_ff  <= ADDR_W'(cur_pos);
         rsp_data_ff <= (cmd_ff == CMD_READ && addr_ok) ? rdata_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         cnt_ff        <= '0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         blank_attr_ff <= RESET_BLANK_ATTR;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         wr_pend_ff <= ctl.copy_rd || ctl.blank_stage;
         priority if (ctl.cnt_zero) begin
            cnt_ff <= '0;
         end else if (ctl.cnt_inc) begin
            cnt_ff <= stat.cnt_last ? '0 : cnt_ff + MEM_AW'(1);
         end
         priority if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            blank_attr_ff <= csr_blank_attribute;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_data       = rsp_data_ff;

   `include "text_console_writer_assert.svh"

   `TCW_ASSERT_NEVER(a_one_writer, clock, reset, wr_pend_ff && direct_we)
   `TCW_ASSERT_NEVER(a_cursor_on_screen, clock, reset,
      col_ff > COL_W'(COLS - 1) || row_ff > ROW_W'(ROWS - 1))
   `TCW_ASSERT_IMPLY(a_scroll_keeps_bottom, clock, reset,
      $past(ctl.exec && stat.need_scroll), row_ff == ROW_W'(ROWS - 1) && col_ff == '0)

endmodule

/* tb/tb_top.sv */
// Testbench for the text console writer: screen model, command driver and result checker.
`timescale 1ns / 1ps

module tb_top import tcw_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 50;
   localparam int PHASE_ITEMS    = 285;

   typedef struct packed {
      logic [ADDR_W-1:0] cursor_position;
      logic [CELL_W-1:0] cell_data;
   } console_reply_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_cmd;
   logic [7:0]        req_char_code;
   logic [7:0]        req_attribute;
   logic [ADDR_W-1:0] req_cell_address;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [ADDR_W-1:0] rsp_cursor_position;
   logic [CELL_W-1:0] rsp_cell_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [7:0]        csr_blank_attribute;

   logic [CELL_W-1:0] screen_model [CELLS];
   int unsigned       model_col;
   int unsigned       model_row;
   logic [7:0]        model_blank_attr;

   console_reply_type console_replies_q [$];
   int                fail_count;
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                rsp_hold_cycles;

   text_console_writer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_char_code       (req_char_code),
      .req_attribute       (req_attribute),
      .req_cell_address    (req_cell_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_data       (rsp_cell_data),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_blank_attribute (csr_blank_attribute)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void advance_row();
      model_row++;
      if (model_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLS; i++)
            screen_model[i] = screen_model[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++)
            screen_model[i] = {model_blank_attr, 8'h00};
         model_row = ROWS - 1;
      end
   endfunction

   function automatic console_reply_type compute_console_reply(input logic [1:0] cmd,
         input logic [7:0] ch, input logic [7:0] attr, input logic [ADDR_W-1:0] addr);
      console_reply_type reply;
      reply.cell_data = '0;
      case (cmd)
         CMD_PUT: begin
            screen_model[model_row * COLS + model_col] = {attr, ch};
            model_col++;
            if (model_col >= COLS) begin
               model_col = 0;
               advance_row();
            end
         end
         CMD_NEWLINE: begin
            model_col = 0;
            advance_row();
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen_model[i] = {model_blank_attr, 8'h00};
         end
         CMD_READ: begin
            if (addr < CELLS)
               reply.cell_data = screen_model[addr];
         end
      endcase
      reply.cursor_position = ADDR_W'(model_row * COLS + model_col);
      return reply;
   endfunction

   task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] ch, input logic [7:0] attr,
         input logic [ADDR_W-1:0] addr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_cmd          = cmd;
      req_char_code    = ch;
      req_attribute    = attr;
      req_cell_address = addr;
      do @(posedge clock); while (!req_ready);
      console_replies_q.push_back(compute_console_reply(cmd, ch, attr, addr));
      @(negedge clock);
   endtask

   task automatic wait_for_replies();
      req_valid = 1'b0;
      while (console_replies_q.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_blank_attribute(input logic [7:0] value);
      csr_valid           = 1'b1;
      csr_blank_attribute = value;
      do @(posedge clock); while (!csr_ready);
      model_blank_attr = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_directed_commands();
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(0));
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(CELLS - 1));
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(CELLS));
      send_cmd(CMD_READ, 8'hFF, 8'hFF, {ADDR_W{1'b1}});
      send_cmd(CMD_PUT, 8'h00, 8'h00, ADDR_W'(0));
      send_cmd(CMD_PUT, 8'hFF, 8'hFF, {ADDR_W{1'b1}});
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(0));
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(1));
      send_cmd(CMD_NEWLINE, 8'hFF, 8'hFF, {ADDR_W{1'b1}});
      send_cmd(CMD_PUT, 8'h41, 8'h1E, ADDR_W'(0));
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(COLS));
      wait_for_replies();
      write_blank_attribute(8'hFF);
      send_cmd(CMD_CLEAR, 8'h5A, 8'hA5, ADDR_W'(0));
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(0));
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(COLS));
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(CELLS - 1));
      wait_for_replies();
      // old blanks keep their attribute
      write_blank_attribute(8'h00);
      send_cmd(CMD_NEWLINE, 8'h00, 8'h00, ADDR_W'(0));
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(0));
      send_cmd(CMD_PUT, 8'h20, 8'h70, ADDR_W'(0));
      send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'(2 * COLS));
      wait_for_replies();
   endtask

   task automatic test_backpressure();
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = 300;
      for (int k = 0; k < 16; k++) begin
         if (k % 2 == 0)
            send_cmd(CMD_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     ADDR_W'(0));
         else
            send_cmd(CMD_READ, 8'h00, 8'h00, ADDR_W'($urandom_range(0, CELLS - 1)));
      end
      wait_for_replies();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
         input logic [7:0] blank_attr);
      int sent;
      int kind;
      int len;
      int pos;
      logic [ADDR_W-1:0] addr;
      wait_for_replies();
      write_blank_attribute(blank_attr);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 10) : $urandom_range(75, 90);
            for (int k = 0; k < len; k++) begin
               send_cmd(CMD_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        ADDR_W'($urandom_range(0, 2047)));
               sent++;
               if ($urandom_range(0, 9) == 0) begin
                  pos = model_row * COLS + model_col;
                  send_cmd(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           ADDR_W'((pos > 0) ? pos - 1 : 0));
                  sent++;
               end
            end
            if ($urandom_range(0, 9) < 7) begin
               send_cmd(CMD_NEWLINE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        ADDR_W'($urandom_range(0, 2047)));
               sent++;
            end
         end else if (kind < 70) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0)
                  addr = ADDR_W'($urandom_range(CELLS, (1 << ADDR_W) - 1));
               else
                  addr = ADDR_W'($urandom_range(0, CELLS - 1));
               send_cmd(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), addr);
               sent++;
            end
         end else if (kind < 90) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
               send_cmd(CMD_NEWLINE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        ADDR_W'($urandom_range(0, 2047)));
               sent++;
            end
         end else if (kind < 95) begin
            send_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     ADDR_W'($urandom_range(0, 2047)));
            sent++;
         end else begin
            send_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), ADDR_W'($urandom_range(0, 2047)));
            sent++;
         end
      end
      wait_for_replies();
   endtask

   initial begin
      console_reply_type want;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (console_replies_q.size() == 0) begin
               $error("result with nothing expected: cursor_position %0d cell_data %h",
                      rsp_cursor_position, rsp_cell_data);
               fail_count++;
            end else begin
               want = console_replies_q.pop_front();
               if (rsp_cursor_position !== want.cursor_position) begin
                  $error("cursor_position: expected %0d, actual %0d",
                         want.cursor_position, rsp_cursor_position);
                  fail_count++;
               end
               if (rsp_cell_data !== want.cell_data) begin
                  $error("cell_data: expected %h, actual %h", want.cell_data, rsp_cell_data);
                  fail_count++;
               end
            end
         end
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_cmd             = CMD_PUT;
      req_char_code       = 8'h00;
      req_attribute       = 8'h00;
      req_cell_address    = '0;
      csr_valid           = 1'b0;
      csr_blank_attribute = 8'h00;
      fail_count          = 0;
      send_idle_pct       = 0;
      rsp_stall_pct       = 0;
      rsp_hold_cycles     = 0;
      for (int i = 0; i < CELLS; i++)
         screen_model[i] = RESET_BLANK;
      model_col        = 0;
      model_row        = 0;
      model_blank_attr = RESET_BLANK_ATTR;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_commands();
      test_backpressure();
      test_random_traffic(0, 0, 8'($urandom_range(0, 255)));
      test_random_traffic(58, 0, 8'hFF);
      test_random_traffic(0, 58, 8'h00);
      test_random_traffic(31, 31, RESET_BLANK_ATTR);

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dp.sv
rtl/core/text_console_writer.sv
tb/tb_top.sv
